// File: hw/rtl/nft_pkg.sv
// ----------------------------------------------------------------------------
// nft_pkg
// Shared types, character codes and microcode table of the names tokenizer.
// ----------------------------------------------------------------------------
package nft_pkg;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_NOMORE = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       at_end;
    } t_nft_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_value;
        logic [7:0] delim_char;
        logic       delim_is_end;
        logic       ws_overflow;
        logic       last;
    } t_nft_out;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_FLUSH,
        OP_HOLD,
        OP_CHAR,
        OP_DOT,
        OP_END,
        OP_NOMORE
    } t_nft_op;

    typedef logic [3:0] t_nft_addr;

    typedef struct packed {
        t_nft_op op;
        logic    done;
    } t_nft_uword;

    typedef struct packed {
        logic    busy;
        logic    fire;
        t_nft_op op;
        logic    last;
    } t_nft_ctl;

    // routine entry points
    localparam t_nft_addr UA_IDLE     = 4'd0;
    localparam t_nft_addr UA_NOMORE   = 4'd1;
    localparam t_nft_addr UA_END      = 4'd2;
    localparam t_nft_addr UA_HOLD     = 4'd3;
    localparam t_nft_addr UA_CHAR     = 4'd4;
    localparam t_nft_addr UA_DOT_END  = 4'd6;
    localparam t_nft_addr UA_DOT_CHAR = 4'd9;
    localparam t_nft_addr UA_DOT      = 4'd12;

    localparam int UCODE_DEPTH = 16;

    localparam t_nft_uword NFT_UCODE [UCODE_DEPTH] = '{
        '{OP_NOP,    1'b1},   // idle
        '{OP_NOMORE, 1'b1},   // no more names
        '{OP_END,    1'b1},   // end of name
        '{OP_HOLD,   1'b1},   // hold whitespace
        '{OP_FLUSH,  1'b0},   // name character
        '{OP_CHAR,   1'b1},
        '{OP_FLUSH,  1'b0},   // period, then end of file
        '{OP_DOT,    1'b0},
        '{OP_END,    1'b1},
        '{OP_FLUSH,  1'b0},   // period, then character
        '{OP_DOT,    1'b0},
        '{OP_CHAR,   1'b1},
        '{OP_FLUSH,  1'b0},   // period, then escape
        '{OP_DOT,    1'b1},
        '{OP_NOP,    1'b1},
        '{OP_NOP,    1'b1}
    };

endpackage

// File: hw/rtl/nft_useq.sv
// ----------------------------------------------------------------------------
// nft_useq
// Microcode sequencer: step counter over the control table, with a
// self-loop while held whitespace drains and a wait on a full output.
// ----------------------------------------------------------------------------
module nft_useq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  nft_pkg::t_nft_addr i_entry,
    input  logic               i_flush_more,
    input  logic               i_can_emit,
    output nft_pkg::t_nft_ctl  o_ctl
);
    import nft_pkg::*;

    t_nft_addr  r_pc;
    t_nft_addr  n_pc;
    t_nft_uword w_uw;
    logic       w_busy;
    logic       w_emits;
    logic       w_fire;

    always_comb begin
        w_uw   = NFT_UCODE[r_pc];
        w_busy = (r_pc != UA_IDLE);
        case (w_uw.op)
            OP_CHAR, OP_DOT, OP_END, OP_NOMORE: begin
                w_emits = 1'b1;
            end
            OP_FLUSH: begin
                w_emits = i_flush_more;
            end
            default: begin
                w_emits = 1'b0;
            end
        endcase
        w_fire = w_busy && (!w_emits || i_can_emit);

        n_pc = r_pc;
        if (!w_busy) begin
            n_pc = i_accept ? i_entry : UA_IDLE;
        end else if (w_fire) begin
            if (w_uw.op == OP_FLUSH && i_flush_more) begin
                n_pc = r_pc;
            end else if (w_uw.done) begin
                n_pc = UA_IDLE;
            end else begin
                n_pc = r_pc + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UA_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = '{busy: w_busy, fire: w_fire, op: w_uw.op, last: w_uw.done};

endmodule

// File: hw/rtl/names_file_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// names_file_tokenizer_unit
// Input is stalled while the one microcode sequencer runs a routine, so a new
// byte is taken only once the last one is through; the sequencer drains held
// whitespace one byte per cycle, unless the output stalls, through one output
// register.
// Reset: skip mode, held count and overflow flag cleared; the hold buffer
// is not cleared.
// ----------------------------------------------------------------------------
module names_file_tokenizer_unit #(
    parameter int HOLD_DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  nft_pkg::t_nft_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output nft_pkg::t_nft_out o_out_data
);
    import nft_pkg::*;

    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(HOLD_DEPTH);

    typedef enum logic [2:0] {
        M_SKIP,
        M_SKIPCMT,
        M_NAME,
        M_DOT,
        M_ESC,
        M_SPACES,
        M_ENDCMT
    } t_mode;

    t_mode           r_mode;
    t_mode           n_mode;
    t_nft_addr       n_entry;
    logic [7:0]      r_c;
    logic            r_eof;
    logic [CW-1:0]   r_held_cnt;
    logic [CW-1:0]   r_rd_idx;
    logic            r_ovf;
    logic [7:0]      r_held_mem [HOLD_DEPTH];
    logic            r_out_valid;
    t_nft_out        r_out;
    t_nft_ctl        w_ctl;
    logic            w_accept;
    logic            w_flush_more;
    logic            w_can_emit;
    logic            w_hold_room;
    logic            w_emit;
    logic [7:0]      w_c;
    logic            w_eof;
    logic            w_ws;

    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_flush_more = (r_rd_idx < r_held_cnt);
    assign w_can_emit   = !r_out_valid || !i_out_stall;
    assign w_hold_room  = (r_held_cnt < DEPTH_C);
    assign w_emit       = w_ctl.fire &&
                          ((w_ctl.op == OP_FLUSH) ? w_flush_more :
                           (w_ctl.op inside {OP_CHAR, OP_DOT, OP_END, OP_NOMORE}));
    assign o_in_stall   = w_ctl.busy;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    nft_useq u_useq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_entry      (n_entry),
        .i_flush_more (w_flush_more),
        .i_can_emit   (w_can_emit),
        .o_ctl        (w_ctl)
    );

    // dispatch: routine entry and next mode
    always_comb begin
        w_c     = i_in_data.in_byte;
        w_eof   = i_in_data.at_end;
        w_ws    = w_c inside {CH_SPACE, CH_NL, CH_TAB};
        n_entry = UA_IDLE;
        n_mode  = r_mode;
        case (r_mode)
            M_SKIPCMT: begin
                if (w_eof) begin
                    n_entry = UA_NOMORE;
                    n_mode  = M_SKIP;
                end else if (w_c == CH_NL) begin
                    n_mode = M_SKIP;
                end
            end
            M_NAME, M_SPACES: begin
                if (r_mode == M_SPACES && !w_eof && w_c == CH_SPACE) begin
                    n_mode = M_SPACES;
                end else if (w_eof || (w_c inside {CH_COLON, CH_COMMA, CH_NL})) begin
                    n_entry = UA_END;
                    n_mode  = M_SKIP;
                end else if (w_c == CH_BAR) begin
                    n_mode = M_ENDCMT;
                end else if (w_c == CH_DOT) begin
                    n_mode = M_DOT;
                end else if (w_c == CH_BSLASH) begin
                    n_mode = M_ESC;
                end else if (w_c == CH_SPACE) begin
                    n_entry = UA_HOLD;
                    n_mode  = M_SPACES;
                end else if (w_c == CH_TAB) begin
                    n_entry = UA_HOLD;
                    n_mode  = M_NAME;
                end else begin
                    n_entry = UA_CHAR;
                    n_mode  = M_NAME;
                end
            end
            M_DOT: begin
                if (w_eof) begin
                    n_entry = UA_DOT_END;
                    n_mode  = M_SKIP;
                end else if (w_c == CH_BAR) begin
                    n_mode = M_ENDCMT;
                end else if (w_ws) begin
                    n_entry = UA_END;
                    n_mode  = M_SKIP;
                end else if (w_c == CH_BSLASH) begin
                    n_entry = UA_DOT;
                    n_mode  = M_ESC;
                end else begin
                    n_entry = UA_DOT_CHAR;
                    n_mode  = M_NAME;
                end
            end
            M_ESC: begin
                if (w_eof) begin
                    n_entry = UA_END;
                    n_mode  = M_SKIP;
                end else if (w_c == CH_SPACE) begin
                    n_entry = UA_HOLD;
                    n_mode  = M_SPACES;
                end else if (w_ws) begin
                    n_entry = UA_HOLD;
                    n_mode  = M_NAME;
                end else begin
                    n_entry = UA_CHAR;
                    n_mode  = M_NAME;
                end
            end
            M_ENDCMT: begin
                if (w_eof || w_c == CH_NL) begin
                    n_entry = UA_END;
                    n_mode  = M_SKIP;
                end
            end
            default: begin
                n_mode = M_SKIP;
                if (w_eof) begin
                    n_entry = UA_NOMORE;
                end else if (w_c == CH_BAR) begin
                    n_mode = M_SKIPCMT;
                end else if (!w_ws) begin
                    if (w_c inside {CH_COLON, CH_COMMA}) begin
                        n_entry = UA_END;
                    end else if (w_c == CH_DOT) begin
                        n_mode = M_DOT;
                    end else if (w_c == CH_BSLASH) begin
                        n_mode = M_ESC;
                    end else begin
                        n_entry = UA_CHAR;
                        n_mode  = M_NAME;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.fire && w_ctl.op == OP_HOLD && w_hold_room) begin
            r_held_mem[r_held_cnt[AW-1:0]] <= r_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_SKIP;
            r_held_cnt  <= '0;
            r_rd_idx    <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_mode <= n_mode;
                r_c    <= i_in_data.in_byte;
                r_eof  <= i_in_data.at_end;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_ctl.fire) begin
                case (w_ctl.op)
                    OP_FLUSH: begin
                        if (w_flush_more) begin
                            r_out <= '{kind: KIND_CHAR,
                                       char_value: r_held_mem[r_rd_idx[AW-1:0]],
                                       delim_char: CH_NUL, delim_is_end: 1'b0,
                                       ws_overflow: 1'b0, last: 1'b0};
                            r_rd_idx <= r_rd_idx + CW'(1);
                        end else begin
                            r_rd_idx   <= '0;
                            r_held_cnt <= '0;
                        end
                    end
                    OP_HOLD: begin
                        if (w_hold_room) begin
                            r_held_cnt <= r_held_cnt + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    OP_CHAR, OP_DOT: begin
                        r_out <= '{kind: KIND_CHAR,
                                   char_value: (w_ctl.op == OP_DOT) ? CH_DOT : r_c,
                                   delim_char: CH_NUL, delim_is_end: 1'b0,
                                   ws_overflow: 1'b0, last: w_ctl.last};
                    end
                    OP_END: begin
                        r_out <= '{kind: KIND_END, char_value: CH_NUL,
                                   delim_char: r_eof ? CH_NUL : r_c,
                                   delim_is_end: r_eof, ws_overflow: r_ovf,
                                   last: w_ctl.last};
                        r_held_cnt <= '0;
                        r_ovf      <= 1'b0;
                    end
                    OP_NOMORE: begin
                        r_out <= '{kind: KIND_NOMORE, char_value: CH_NUL,
                                   delim_char: CH_NUL, delim_is_end: 1'b0,
                                   ws_overflow: 1'b0, last: w_ctl.last};
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
